[rtl/psss_pkg.sv]
// Shared constants, tables and types for the power stage sag saturator.
// Tables are built at elaboration by constant functions; no dependencies.
package psss_pkg;

  localparam int RIPPLE_PHASE_STEP = 137;
  localparam int TANH_TABLE_DEPTH  = 256;
  localparam int SINE_TABLE_DEPTH  = 256;
  localparam int TANH_LOG          = $clog2(TANH_TABLE_DEPTH);
  localparam int SINE_LOG          = $clog2(SINE_TABLE_DEPTH);

  // shared multiplier operand and product widths
  localparam int OP_W   = 35;
  localparam int PROD_W = 2 * OP_W;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned Q30_MASK    = 64'h3FFF_FFFF;
  localparam longint unsigned INV_E_Q30   = 64'd395007542;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [19:0] SAG_CAP_Q21   = 20'd1006633;
  localparam logic [31:0] XO_BASE_Q30   = 32'd944892805;
  localparam logic [31:0] XO_REF_Q30    = 32'd75161928;
  localparam logic [17:0] XO_SLOPE_Q16  = 18'd203162;
  localparam logic [31:0] XO_RECIP3     = 32'hAAAA_AAAB;  // (2^33 + 1) / 3
  localparam logic [29:0] OUT_SCALE_Q30 = 30'd923417969;
  localparam logic [21:0] OUT_LIMIT     = 22'd1803551;
  localparam logic [22:0] ENV_MAX       = 23'h7F_FFFF;

  // register indexes on the config port
  localparam logic [2:0] CFG_ATTACK     = 3'd0;
  localparam logic [2:0] CFG_RELEASE    = 3'd1;
  localparam logic [2:0] CFG_DRIVE      = 3'd2;
  localparam logic [2:0] CFG_FEEDBACK   = 3'd3;
  localparam logic [2:0] CFG_SAG        = 3'd4;
  localparam logic [2:0] CFG_RIPPLE     = 3'd5;
  localparam logic [2:0] CFG_XO_THRESH  = 3'd6;
  localparam logic [2:0] CFG_SAT_GAIN   = 3'd7;

  typedef logic signed [31:0] tanh_tab_t [0:TANH_TABLE_DEPTH];
  typedef logic signed [31:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // shift-subtract quotient for the elaboration-time table builders
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned exp_neg_frac(longint unsigned f);
    longint unsigned term;
    longint          sum;
    longint unsigned nu;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    for (int n = 1; n <= 13; n++) begin
      nu   = 64'(n);
      term = udiv((term * f) >> 30, nu);
      if ((n & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    return longint'(sum);
  endfunction

  function automatic longint sin_quarter(longint unsigned ang);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned den;
    longint          sum;
    x2   = (ang * ang) >> 30;
    term = ang;
    sum  = longint'(ang);
    for (int n = 1; n <= 7; n++) begin
      den  = 64'((2 * n) * (2 * n + 1));
      term = udiv((term * x2) >> 30, den);
      if ((n & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    return sum;
  endfunction

  function automatic tanh_tab_t build_tanh();
    tanh_tab_t       t;
    longint unsigned iu;
    longint unsigned y;
    longint unsigned m;
    longint unsigned e;
    for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      iu = 64'(i);
      y  = udiv((iu * 64'd16) << 30, 64'(TANH_TABLE_DEPTH));
      m  = y >> 30;
      e  = exp_neg_frac(y & Q30_MASK);
      for (longint unsigned k = 0; k < m; k++) e = (e * INV_E_Q30) >> 30;
      if (e > Q30_ONE) e = Q30_ONE;
      t[i] = 32'(udiv((Q30_ONE - e) << 30, Q30_ONE + e));
    end
    return t;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t       t;
    longint unsigned ku;
    longint unsigned ph;
    longint unsigned quad;
    longint unsigned r;
    longint          s;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      ku   = 64'(k);
      ph   = udiv(ku << 32, 64'(SINE_TABLE_DEPTH)) & 64'hFFFF_FFFF;
      quad = ph >> 30;
      r    = ph & Q30_MASK;
      if (quad[0]) r = Q30_ONE - r;
      s    = sin_quarter((r * HALF_PI_Q30) >> 30);
      t[k] = (quad >= 64'd2) ? 32'(-s) : 32'(s);
    end
    return t;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();
  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

[rtl/psss_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on psss_pkg for operand and product widths.
module psss_mul (
  input  logic                               clk,
  input  logic signed [psss_pkg::OP_W-1:0]   a,
  input  logic signed [psss_pkg::OP_W-1:0]   b,
  output logic signed [psss_pkg::PROD_W-1:0] p
);
  import psss_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

[rtl/power_stage_sag_saturator.sv]
// Top level of the power stage sag saturator: sequencer, state and config.
// Depends on psss_pkg and psss_mul.
//
// One Q2.21 sample enters on in_valid/in_stall and one Q0.21 sample leaves on
// out_valid/out_stall. A beat moves when valid is high and stall is low.
// Each sample runs through a 21-step sequence around one shared multiplier,
// one product per cycle: envelope, sine ripple, feedback, sag, drive, two
// table-interpolated tanh stages, crossover shaping and output scaling.
// in_stall is high from the input beat until the result is loaded into the
// output register, when out_valid rises, so a new sample is taken only once
// the previous one has finished its sequence.
// A result waiting in the output register does not block the next sample; if
// the previous result is still stalled when a new one is done, the sequencer
// holds in its last step until the output register frees up.
// Config writes (cfg_write, cfg_index, cfg_data) take effect at once and are
// expected only while no sample is in flight.
// rst (synchronous) restores the register defaults, clears envelope, ripple
// phase and last output, and empties the output register.
module power_stage_sag_saturator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [21:0] out_sample,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);
  import psss_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_ENV  = 5'd1;
  localparam logic [4:0] ST_SIN  = 5'd2;
  localparam logic [4:0] ST_FB   = 5'd3;
  localparam logic [4:0] ST_RIP  = 5'd4;
  localparam logic [4:0] ST_SAG  = 5'd5;
  localparam logic [4:0] ST_DRV  = 5'd6;
  localparam logic [4:0] ST_FAC  = 5'd7;
  localparam logic [4:0] ST_V    = 5'd8;
  localparam logic [4:0] ST_XDIV = 5'd9;
  localparam logic [4:0] ST_T1   = 5'd10;
  localparam logic [4:0] ST_T1M  = 5'd11;
  localparam logic [4:0] ST_T1Y  = 5'd12;
  localparam logic [4:0] ST_XO   = 5'd13;
  localparam logic [4:0] ST_XOY  = 5'd14;
  localparam logic [4:0] ST_Z    = 5'd15;
  localparam logic [4:0] ST_T2   = 5'd16;
  localparam logic [4:0] ST_T2M  = 5'd17;
  localparam logic [4:0] ST_T2Y  = 5'd18;
  localparam logic [4:0] ST_OUT  = 5'd19;
  localparam logic [4:0] ST_DONE = 5'd20;
  localparam logic [4:0] ST_SEND = 5'd21;

  // config registers
  logic [15:0] attack_coef;
  logic [15:0] release_coef;
  logic [19:0] drive_gain;
  logic [15:0] feedback_scale;
  logic [14:0] sag_scale;
  logic [10:0] ripple_depth;
  logic [13:0] crossover_threshold;
  logic [16:0] saturation_gain;

  // persistent state
  logic [22:0]        env;
  logic signed [23:0] last;
  logic [15:0]        phase;

  // per-sample working registers
  logic [4:0]         state;
  logic signed [23:0] x;
  logic               up;
  logic signed [31:0] sin_s;
  logic signed [25:0] diff;
  logic signed [26:0] ripple;
  logic [19:0]        sag;
  logic signed [31:0] d1;
  logic signed [32:0] factor;
  logic [31:0]        xmag;
  logic               xneg;
  logic signed [33:0] v;
  logic signed [33:0] base;
  logic               shape;
  logic [32:0]        slope;
  logic signed [33:0] xmult;
  logic signed [33:0] y;
  logic signed [31:0] t2;
  logic               tsign;
  logic               tsat;
  logic [TANH_LOG-1:0] ti;
  logic [29:0]        tf;

  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] p;

  psss_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  logic signed [PROD_W-1:0] p_s16, p_s30, p_s39;
  assign p_s16 = p >>> 16;
  assign p_s30 = p >>> 30;
  assign p_s39 = p >>> 39;

  // envelope target
  logic [23:0] xabs;
  logic [22:0] target;
  logic        up_c;
  logic [22:0] dlt;
  assign xabs   = x[23] ? 24'(-x) : 24'(x);
  assign target = (xabs > 24'(ENV_MAX)) ? ENV_MAX : xabs[22:0];
  assign up_c   = target > env;
  assign dlt    = up_c ? (target - env) : (env - target);

  // sine table position
  logic [31:0]         spos;
  logic [SINE_LOG:0]   si_lo, si_hi;
  logic signed [32:0]  sdelta;
  assign spos   = 32'(phase) << SINE_LOG;
  assign si_lo  = {1'b0, spos[16 +: SINE_LOG]};
  assign si_hi  = si_lo + 1'b1;
  assign sdelta = 33'(SINE_TAB[si_hi]) - 33'(SINE_TAB[si_lo]);

  // crossover base numerator, 8 * (thr * 2^14 - ref)
  logic signed [34:0] xm;
  assign xm = 35'sd8 * (35'({crossover_threshold, 14'b0}) - 35'(XO_REF_Q30));

  logic [33:0] absv;
  assign absv = v[33] ? 34'(-v) : 34'(v);

  // tanh table position for the next stage to run
  logic signed [33:0] zc;
  logic [35:0]        zabs;
  logic [63:0]        tl_mag;
  logic [63:0]        tpos;
  logic [33:0]        tl_idx;
  logic               tl_neg;
  assign zc     = 34'(p_s16);
  assign zabs   = zc[33] ? 36'(-zc) : 36'(zc);
  assign tl_mag = (state == ST_T1) ? (64'(absv) << 9) : 64'(zabs);
  assign tl_neg = (state == ST_T1) ? v[33] : zc[33];
  assign tpos   = (tl_mag << TANH_LOG) >> 3;
  assign tl_idx = tpos[63:30];

  logic [TANH_LOG:0]  ti_lo, ti_hi;
  logic signed [32:0] tdelta;
  logic signed [33:0] tr;
  logic signed [33:0] tres;
  assign ti_lo  = {1'b0, ti};
  assign ti_hi  = ti_lo + 1'b1;
  assign tdelta = 33'(TANH_TAB[ti_hi]) - 33'(TANH_TAB[ti_lo]);
  assign tr     = tsat ? 34'(TANH_TAB[TANH_TABLE_DEPTH])
                       : 34'(TANH_TAB[ti_lo]) + 34'(p_s30);
  assign tres   = tsign ? -tr : tr;

  logic [31:0]        q3;
  logic signed [33:0] q3s;
  assign q3  = 32'(p >>> 33);
  assign q3s = xneg ? -34'(q3) : 34'(q3);

  // signed clamp of the scaled output
  logic signed [23:0] oc;
  assign oc = (p_s39 > $signed(PROD_W'(OUT_LIMIT)))  ? 24'(OUT_LIMIT) :
              (p_s39 < -$signed(PROD_W'(OUT_LIMIT))) ? -24'(OUT_LIMIT) : 24'(p_s39);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_ENV: begin
        mul_a = OP_W'(up_c ? attack_coef : release_coef);
        mul_b = OP_W'(dlt);
      end
      ST_SIN: begin
        mul_a = OP_W'(sdelta);
        mul_b = OP_W'(spos[15:0]);
      end
      ST_FB: begin
        mul_a = OP_W'(last);
        mul_b = OP_W'(feedback_scale);
      end
      ST_RIP: begin
        mul_a = OP_W'(ripple_depth);
        mul_b = OP_W'(sin_s);
      end
      ST_SAG: begin
        mul_a = OP_W'(env);
        mul_b = OP_W'(sag_scale);
      end
      ST_DRV: begin
        mul_a = OP_W'(diff);
        mul_b = OP_W'(drive_gain);
      end
      ST_V: begin
        mul_a = OP_W'(d1);
        mul_b = OP_W'(factor);
      end
      ST_XDIV: begin
        mul_a = OP_W'(xmag);
        mul_b = OP_W'(XO_RECIP3);
      end
      ST_T1: begin
        mul_a = OP_W'(absv);
        mul_b = OP_W'(XO_SLOPE_Q16);
      end
      ST_T1M, ST_T2M: begin
        mul_a = OP_W'(tdelta);
        mul_b = OP_W'(tf);
      end
      ST_XO: begin
        mul_a = OP_W'(y);
        mul_b = OP_W'(xmult);
      end
      ST_Z: begin
        mul_a = OP_W'(y);
        mul_b = OP_W'(saturation_gain);
      end
      ST_OUT: begin
        mul_a = OP_W'(t2);
        mul_b = OP_W'(OUT_SCALE_Q30);
      end
      default: ;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coef         <= 16'd170;
      release_coef        <= 16'd16;
      drive_gain          <= 20'd340787;
      feedback_scale      <= 16'd13107;
      sag_scale           <= 15'd6140;
      ripple_depth        <= 11'd0;
      crossover_threshold <= 14'd6553;
      saturation_gain     <= 17'd80282;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ATTACK:    attack_coef         <= cfg_data[15:0];
        CFG_RELEASE:   release_coef        <= cfg_data[15:0];
        CFG_DRIVE:     drive_gain          <= cfg_data;
        CFG_FEEDBACK:  feedback_scale      <= cfg_data[15:0];
        CFG_SAG:       sag_scale           <= cfg_data[14:0];
        CFG_RIPPLE:    ripple_depth        <= cfg_data[10:0];
        CFG_XO_THRESH: crossover_threshold <= cfg_data[13:0];
        CFG_SAT_GAIN:  saturation_gain     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      env       <= '0;
      last      <= '0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_SEND && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x     <= in_sample;
            state <= ST_ENV;
          end
        end
        ST_ENV: begin
          up    <= up_c;
          phase <= phase + 16'(RIPPLE_PHASE_STEP);
          state <= ST_SIN;
        end
        ST_SIN: begin
          env   <= up ? env + 23'(p_s16) : env - 23'(p_s16);
          state <= ST_FB;
        end
        ST_FB: begin
          sin_s <= SINE_TAB[si_lo] + 32'(p_s16);
          state <= ST_RIP;
        end
        ST_RIP: begin
          diff  <= 26'(x) - 26'(p_s16);
          state <= ST_SAG;
        end
        ST_SAG: begin
          ripple <= 27'(p_s16);
          state  <= ST_DRV;
        end
        ST_DRV: begin
          sag   <= (p_s16 > PROD_W'(SAG_CAP_Q21)) ? SAG_CAP_Q21 : 20'(p_s16);
          state <= ST_FAC;
        end
        ST_FAC: begin
          d1     <= 32'(p_s16);
          factor <= 33'(Q30_ONE) - 33'({sag, 9'b0}) + 33'(ripple);
          xneg   <= xm[34];
          xmag   <= xm[34] ? 32'(-xm) : 32'(xm);
          state  <= ST_V;
        end
        ST_V:    state <= ST_XDIV;
        ST_XDIV: begin
          v     <= 34'(p_s30);
          state <= ST_T1;
        end
        ST_T1: begin
          base  <= 34'(XO_BASE_Q30) - q3s;
          shape <= (crossover_threshold != '0) &&
                   (absv < 34'({crossover_threshold, 5'b0}));
          tsign <= tl_neg;
          tsat  <= tl_idx >= 34'(TANH_TABLE_DEPTH);
          ti    <= tl_idx[TANH_LOG-1:0];
          tf    <= tpos[29:0];
          state <= ST_T1M;
        end
        ST_T1M: begin
          slope <= 33'(p >>> 7);
          state <= ST_T1Y;
        end
        ST_T1Y: begin
          y     <= tres;
          xmult <= base + 34'(slope);
          state <= ST_XO;
        end
        ST_XO:   state <= ST_XOY;
        ST_XOY: begin
          if (shape) y <= 34'(p_s30);
          state <= ST_Z;
        end
        ST_Z:    state <= ST_T2;
        ST_T2: begin
          tsign <= tl_neg;
          tsat  <= tl_idx >= 34'(TANH_TABLE_DEPTH);
          ti    <= tl_idx[TANH_LOG-1:0];
          tf    <= tpos[29:0];
          state <= ST_T2M;
        end
        ST_T2M:  state <= ST_T2Y;
        ST_T2Y: begin
          t2    <= 32'(tres);
          state <= ST_OUT;
        end
        ST_OUT:  state <= ST_DONE;
        ST_DONE: begin
          last  <= oc;
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (!out_valid || !out_stall) begin
            out_sample <= last[21:0];
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_ENV)
    else $error("accepted beat did not start the sequence");

  a_sag_capped: assert property (@(posedge clk) disable iff (rst)
    $past(state) == ST_DRV |-> sag <= SAG_CAP_Q21)
    else $error("sag above cap");

  a_last_limited: assert property (@(posedge clk) disable iff (rst)
    last <= 24'sd1803551 && last >= -24'sd1803551)
    else $error("last output out of range");

  a_out_from_send: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_SEND)
    else $error("output beat raised outside send step");

endmodule
